// ===== design/greedy_box_suppression_defines.svh =====
// Assertion macros shared by the greedy box suppression RTL.
// Depends on nothing; files that assert include it and provide i_clk and i_rst_n.
`ifndef GREEDY_BOX_SUPPRESSION_DEFINES_SVH
`define GREEDY_BOX_SUPPRESSION_DEFINES_SVH

`ifndef SYNTHESIS

// A property checked at every clock edge outside reset.
`define GBS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("greedy_box_suppression: assertion failed");

// A property that must hold in the cycle after a trigger.
`define GBS_ASSERT_NEXT(label, trig, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error("greedy_box_suppression: assertion failed");

`else

`define GBS_ASSERT(label, prop)
`define GBS_ASSERT_NEXT(label, trig, prop)

`endif

`endif

// ===== design/gbs_pkg.sv =====
// Shared types, constants and codes of the greedy box suppression block.
// Used by gbs_ctrl, gbs_datapath and the top level; depends on nothing.
package gbs_pkg;

    localparam int MAX_KEPT_DEF = 256;

    localparam int COORD_W    = 16;
    localparam int LABEL_W    = 8;
    localparam int AREA_W     = 2 * COORD_W;
    localparam int UNI_W      = AREA_W + 1;
    localparam int THR_W      = 16;
    localparam int PROD_W     = THR_W + UNI_W;
    localparam int IDX_W      = 16;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd29491;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_AGNOSTIC  = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AREA,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic area_calc;
        logic scan_start;
        logic scan_issue;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } t_status;

    // One stored box.
    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic [LABEL_W-1:0] label;
        logic [AREA_W-1:0]  area;
    } t_kept;

endpackage

// ===== design/gbs_ctrl.sv =====
// Controller state machine of the greedy box suppression block.
// Depends on gbs_pkg and greedy_box_suppression_defines.svh; drives gbs_datapath.
`include "greedy_box_suppression_defines.svh"

module gbs_ctrl
    import gbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    output logic    o_s_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) n_state = ST_AREA;
            end
            ST_AREA: begin
                n_state = i_status.count_zero ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.scan_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_ready     = 1'b1;
                o_cmd.capture = i_s_valid;
            end
            ST_AREA: begin
                o_cmd.area_calc  = 1'b1;
                o_cmd.scan_start = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.scan_issue = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_FINISH: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

    // No comparison may still be in flight while a new box can be taken.
    `GBS_ASSERT(a_idle_drained, o_s_ready |-> !i_status.pipe_busy)

endmodule

// ===== design/gbs_datapath.sv =====
// Datapath of the greedy box suppression block: configuration registers, kept-box
// memory, overlap compare pipeline and output register. Depends on gbs_pkg and
// greedy_box_suppression_defines.svh.
`include "greedy_box_suppression_defines.svh"

module gbs_datapath
    import gbs_pkg::*;
#(
    parameter int MAX_KEPT = MAX_KEPT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata
);

    localparam int IW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam logic [CW-1:0] KEPT_LIMIT = CW'(MAX_KEPT);
    localparam int M_PAD = M_TDATA_W - (IDX_W + 2);

    function automatic logic [COORD_W-1:0] span_overlap(
        input logic [COORD_W-1:0] a0,
        input logic [COORD_W-1:0] alen,
        input logic [COORD_W-1:0] b0,
        input logic [COORD_W-1:0] blen
    );
        logic [COORD_W:0] a1;
        logic [COORD_W:0] b1;
        logic [COORD_W:0] lo;
        logic [COORD_W:0] hi;
        a1 = {1'b0, a0} + {1'b0, alen};
        b1 = {1'b0, b0} + {1'b0, blen};
        lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
        hi = (a1 < b1) ? a1 : b1;
        span_overlap = (hi > lo) ? COORD_W'(hi - lo) : '0;
    endfunction

    // Configuration.
    logic [THR_W-1:0] r_threshold;
    logic             r_agnostic;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
            r_agnostic  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_wdata[THR_W-1:0];
                CFG_AGNOSTIC:  r_agnostic  <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Current box.
    logic [LABEL_W-1:0] r_cur_label;
    logic [COORD_W-1:0] r_cur_left;
    logic [COORD_W-1:0] r_cur_top;
    logic [COORD_W-1:0] r_cur_w;
    logic [COORD_W-1:0] r_cur_h;
    logic [AREA_W-1:0]  r_area;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cur_label <= i_s_tdata[7:0];
            r_cur_left  <= i_s_tdata[23:8];
            r_cur_top   <= i_s_tdata[39:24];
            r_cur_w     <= i_s_tdata[55:40];
            r_cur_h     <= i_s_tdata[71:56];
        end
        if (i_cmd.area_calc) begin
            r_area <= AREA_W'(r_cur_w) * AREA_W'(r_cur_h);
        end
    end

    // List state.
    logic [CW-1:0]    r_kept_cnt;
    logic [IDX_W-1:0] r_item_cnt;
    logic [CW-1:0]    r_scan;
    logic             r_supp;
    logic             store_en;

    assign store_en = i_cmd.finish && !r_supp && (r_kept_cnt < KEPT_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept_cnt <= '0;
            r_item_cnt <= '0;
        end else begin
            if (i_cmd.capture && i_s_tuser) begin
                r_kept_cnt <= '0;
                r_item_cnt <= '0;
            end
            if (i_cmd.finish) begin
                r_item_cnt <= r_item_cnt + IDX_W'(1);
            end
            if (store_en) begin
                r_kept_cnt <= r_kept_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_scan <= '0;
        end else if (i_cmd.scan_issue) begin
            r_scan <= r_scan + CW'(1);
        end
    end

    // Kept-box memory.
    t_kept r_mem [MAX_KEPT];
    t_kept r_rd;

    always_ff @(posedge i_clk) begin
        if (store_en) begin
            r_mem[r_kept_cnt[IW-1:0]] <= '{left: r_cur_left, top: r_cur_top,
                                           width: r_cur_w, height: r_cur_h,
                                           label: r_cur_label, area: r_area};
        end
        if (i_cmd.scan_issue) begin
            r_rd <= r_mem[r_scan[IW-1:0]];
        end
    end

    // Overlap compare pipeline.
    logic               r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [COORD_W-1:0] r_w2, r_h2;
    logic [AREA_W-1:0]  r_ka2, r_ka3;
    logic               r_m2, r_m3, r_m4, r_m5;
    logic [AREA_W-1:0]  r_inter3, r_inter4, r_inter5;
    logic [UNI_W-1:0]   r_uni4;
    logic [PROD_W-1:0]  r_prod5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w2  <= span_overlap(r_cur_left, r_cur_w, r_rd.left, r_rd.width);
        r_h2  <= span_overlap(r_cur_top, r_cur_h, r_rd.top, r_rd.height);
        r_ka2 <= r_rd.area;
        r_m2  <= r_agnostic || (r_rd.label == r_cur_label);

        r_inter3 <= AREA_W'(r_w2) * AREA_W'(r_h2);
        r_ka3    <= r_ka2;
        r_m3     <= r_m2;

        r_uni4   <= UNI_W'(r_area) + UNI_W'(r_ka3) - UNI_W'(r_inter3);
        r_inter4 <= r_inter3;
        r_m4     <= r_m3;

        r_prod5  <= PROD_W'(r_threshold) * PROD_W'(r_uni4);
        r_inter5 <= r_inter4;
        r_m5     <= r_m4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supp <= 1'b0;
        end else if (i_cmd.capture) begin
            r_supp <= 1'b0;
        end else if (r_v5 && r_m5 && (PROD_W'({r_inter5, THR_W'(0)}) > r_prod5)) begin
            r_supp <= 1'b1;
        end
    end

    // Output register.
    logic             r_out_valid;
    logic             r_out_keep;
    logic             r_out_ovf;
    logic [IDX_W-1:0] r_out_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_keep <= !r_supp;
            r_out_ovf  <= !r_supp && (r_kept_cnt >= KEPT_LIMIT);
            r_out_idx  <= r_item_cnt;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {M_PAD'(0), r_out_ovf, r_out_idx, r_out_keep};

    assign o_status.count_zero = (r_kept_cnt == '0);
    assign o_status.scan_last  = (CW'(r_scan + CW'(1)) == r_kept_cnt);
    assign o_status.pipe_busy  = r_v1 | r_v2 | r_v3 | r_v4 | r_v5;
    assign o_status.out_free   = !r_out_valid || i_m_tready;

    `GBS_ASSERT(a_cnt_bound, r_kept_cnt <= KEPT_LIMIT)
    `GBS_ASSERT(a_scan_written, i_cmd.scan_issue |-> (r_scan < r_kept_cnt))
    `GBS_ASSERT_NEXT(a_ovf_only_kept, i_cmd.finish, r_out_keep || !r_out_ovf)

endmodule

// ===== design/greedy_box_suppression.sv =====
// Greedy non-maximum suppression: one input word is one box, sorted by falling score
// by the sender, and one output word per box tells whether it survives, its position
// in the current list and whether the kept-box store was full. A box with the first
// flag in tuser empties the kept list and restarts the position count. Each box is
// checked against every kept box (same label only unless class_agnostic is set) with
// the test inter * 65536 > threshold * union, so empty boxes are always kept. The
// kept-box memory has one read port and feeds one comparison per cycle into a
// five-stage compare pipeline, which is drained before the result is posted. The
// output register lets a new box be accepted while the last result still waits.
// The store needs no clearing pass after reset, since only entries below the kept
// count are ever read. Depends on gbs_pkg, gbs_ctrl, gbs_datapath and
// greedy_box_suppression_defines.svh.
module greedy_box_suppression
    import gbs_pkg::*;
#(
    parameter int MAX_KEPT = MAX_KEPT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port: index 0 is overlap_threshold, index 1 class_agnostic.
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Box input.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // class_label [7:0], left [23:8], top [39:24], box_width [55:40], box_height [71:56]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // first_box [0]
    input  logic                  s_axis_tuser,
    // Result output.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // keep [0], item_index [16:1], overflow [17], zero [23:18]
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    t_cmd    cmd;
    t_status status;

    // The controller sequences capture, area, the scan over the kept boxes, the
    // pipeline drain and the posting of the result.
    gbs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_cmd     (cmd),
        .i_status  (status)
    );

    // The datapath holds the registers, the kept-box memory and the compare pipeline.
    gbs_datapath #(
        .MAX_KEPT (MAX_KEPT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

// ===== bench/box_suppression_checker.sv =====
// Checker for the greedy box suppression block: watches the configuration port and both
// word channels, predicts each result word and compares it. Depends on gbs_pkg.
`timescale 1ns / 100ps

module box_suppression_checker
    import gbs_pkg::*;
#(
    parameter int MAX_KEPT = MAX_KEPT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_box_tvalid,
    input  logic                  i_box_tready,
    // class_label [7:0], left [23:8], top [39:24], box_width [55:40], box_height [71:56]
    input  logic [S_TDATA_W-1:0]  i_box_tdata,
    // first_box [0]
    input  logic                  i_box_tuser,
    input  logic                  i_res_tvalid,
    input  logic                  i_res_tready,
    // keep [0], item_index [16:1], overflow [17]
    input  logic [M_TDATA_W-1:0]  i_res_tdata,
    output int                    o_errors,
    output int                    o_pending
);

    typedef struct packed {
        logic             keep;
        logic [IDX_W-1:0] index;
        logic             overflow;
    } t_verdict;

    logic [COORD_W-1:0] kept_left  [MAX_KEPT];
    logic [COORD_W-1:0] kept_top   [MAX_KEPT];
    logic [COORD_W-1:0] kept_w     [MAX_KEPT];
    logic [COORD_W-1:0] kept_h     [MAX_KEPT];
    logic [LABEL_W-1:0] kept_label [MAX_KEPT];
    logic [AREA_W-1:0]  kept_area  [MAX_KEPT];
    int unsigned        kept_n;
    logic [IDX_W-1:0]   list_pos;
    logic [THR_W-1:0]   iou_limit;
    logic               all_labels;
    t_verdict           verdicts_due[$];
    int                 fail_count = 0;
    int                 results_seen;

    assign o_errors = fail_count;

    task automatic report_mismatch(input string what, input logic [31:0] expv,
                                   input logic [31:0] gotv);
        $display("MISMATCH result %0d: %s expected 0x%0h, got 0x%0h",
                 results_seen, what, expv, gotv);
        fail_count++;
    endtask

    function automatic longint unsigned span_overlap(input longint unsigned a0, alen,
                                                     input longint unsigned b0, blen);
        longint unsigned lo, hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
        return (hi > lo) ? hi - lo : 64'd0;
    endfunction

    // Runs one box through the kept list and updates the list the way the block does.
    function automatic t_verdict judge_box(input logic first, input logic [LABEL_W-1:0] label,
                                           input logic [COORD_W-1:0] left, top,
                                           input logic [COORD_W-1:0] width, height);
        longint unsigned area, inter, uni;
        t_verdict        v;
        v.keep     = 1'b1;
        v.overflow = 1'b0;
        if (first) begin
            kept_n   = 0;
            list_pos = '0;
        end
        area = 64'(width) * 64'(height);
        for (int j = 0; j < kept_n; j++) begin
            if (!all_labels && kept_label[j] != label)
                continue;
            inter = span_overlap(64'(left), 64'(width), 64'(kept_left[j]), 64'(kept_w[j]))
                  * span_overlap(64'(top), 64'(height), 64'(kept_top[j]), 64'(kept_h[j]));
            uni = area + 64'(kept_area[j]) - inter;
            if ((inter << 16) > 64'(iou_limit) * uni)
                v.keep = 1'b0;
        end
        if (v.keep) begin
            if (kept_n < MAX_KEPT) begin
                kept_left[kept_n]  = left;
                kept_top[kept_n]   = top;
                kept_w[kept_n]     = width;
                kept_h[kept_n]     = height;
                kept_label[kept_n] = label;
                kept_area[kept_n]  = area[AREA_W-1:0];
                kept_n++;
            end else begin
                v.overflow = 1'b1;
            end
        end
        v.index  = list_pos;
        list_pos = list_pos + IDX_W'(1);
        return v;
    endfunction

    always @(posedge i_clk) begin : track
        t_verdict due;
        t_verdict seen;
        if (!i_rst_n) begin
            kept_n       = 0;
            list_pos     = '0;
            iou_limit    = THRESHOLD_RESET;
            all_labels   = 1'b0;
            results_seen = 0;
            verdicts_due.delete();
        end else begin
            // The result is checked before the box of the same edge is queued, so a
            // word that shows up before its box could have been judged is caught.
            if (i_res_tvalid && i_res_tready) begin
                seen.keep     = i_res_tdata[0];
                seen.index    = i_res_tdata[16:1];
                seen.overflow = i_res_tdata[17];
                if (verdicts_due.size() == 0) begin
                    report_mismatch("result word with no box pending", 32'd0,
                                    32'(i_res_tdata));
                end else begin
                    due = verdicts_due.pop_front();
                    if (seen.keep !== due.keep)
                        report_mismatch("keep", 32'(due.keep), 32'(seen.keep));
                    if (seen.index !== due.index)
                        report_mismatch("item_index", 32'(due.index), 32'(seen.index));
                    if (seen.overflow !== due.overflow)
                        report_mismatch("overflow", 32'(due.overflow), 32'(seen.overflow));
                end
                results_seen++;
            end
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_THRESHOLD)
                    iou_limit = i_cfg_wdata[THR_W-1:0];
                else if (i_cfg_index == CFG_AGNOSTIC)
                    all_labels = i_cfg_wdata[0];
            end
            if (i_box_tvalid && i_box_tready)
                verdicts_due.insert(verdicts_due.size(),
                                    judge_box(i_box_tuser, i_box_tdata[7:0],
                                              i_box_tdata[23:8], i_box_tdata[39:24],
                                              i_box_tdata[55:40], i_box_tdata[71:56]));
        end
        o_pending <= verdicts_due.size();
    end

endmodule

// ===== bench/tb_greedy_box_suppression.sv =====
// Top of the greedy box suppression testbench: clock, reset, box stimulus, result
// back-pressure and the verdict. Depends on gbs_pkg, the block and box_suppression_checker.
`timescale 1ns / 100ps

module tb_greedy_box_suppression;
    import gbs_pkg::*;

    // Long receiver hold-off, in cycles; far longer than one box takes, so the block
    // fills its output register, stalls its input and the sender sits waiting.
    localparam int RX_HOLD_CYCLES = 800;
    // Generous end of the run: several times the slowest correct run.
    localparam longint LIMIT_NS = 64'd40_000_000;

    typedef struct packed {
        logic               first;
        logic [LABEL_W-1:0] label;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
    } t_box_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_ADDR_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // class_label [7:0], left [23:8], top [39:24], box_width [55:40], box_height [71:56]
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    // first_box [0]
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // keep [0], item_index [16:1], overflow [17], zero [23:18]
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    int errors;
    int pending;

    // Knobs shared between the sender and the receiver processes.
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_req   = 1'b0;

    greedy_box_suppression dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    box_suppression_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_box_tvalid (s_axis_tvalid),
        .i_box_tready (s_axis_tready),
        .i_box_tdata  (s_axis_tdata),
        .i_box_tuser  (s_axis_tuser),
        .i_res_tvalid (m_axis_tvalid),
        .i_res_tready (m_axis_tready),
        .i_res_tdata  (m_axis_tdata),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #(LIMIT_NS);
        $display("tb_greedy_box_suppression failed");
        $finish;
    end

    // Mostly back-to-back words, some short gaps and a few gaps as long as a full scan,
    // so that new boxes land on every phase of the block's compare loop.
    function automatic int sender_gap();
        int r;
        if (!tx_idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    function automatic int receiver_stall();
        int r;
        if (!rx_idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_box_word mk_box(input logic first, input int label,
                                         input int left, input int top,
                                         input int width, input int height);
        t_box_word b;
        b.first  = first;
        b.label  = LABEL_W'(label);
        b.left   = COORD_W'(left);
        b.top    = COORD_W'(top);
        b.width  = COORD_W'(width);
        b.height = COORD_W'(height);
        return b;
    endfunction

    // Offers one box word and waits for the handshake. tvalid stays high into the next
    // box unless a gap follows, so it is never lowered and raised in the same step.
    task automatic send_box(input t_box_word b);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= b.first;
        s_axis_tdata  <= {b.height, b.width, b.top, b.left, b.label};
        do @(posedge i_clk); while (!s_axis_tready);
        gap = sender_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops offering and waits until every queued box has its result word back.
    // The checker's pending count is registered, so the first edge makes sure a box
    // accepted at the current edge is already counted.
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Both registers are written back to back while the block is idle. The upper bits
    // of the class_agnostic write carry noise, which the block must ignore.
    task automatic write_config(input logic [THR_W-1:0] thr, input logic agnostic);
        wait_drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_THRESHOLD;
        i_cfg_wdata <= thr;
        @(posedge i_clk);
        i_cfg_index <= CFG_AGNOSTIC;
        i_cfg_wdata <= {15'($urandom_range(0, 32767)), agnostic};
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // A list of boxes scattered around a few cluster centers, so that overlaps range
    // from none to near-identical and IoU values straddle the threshold. A few words
    // are fully random (every field bit toggles), a few are empty, and the first-box
    // flag is sometimes missing at the head or set in the middle of a list.
    task automatic send_random_list(input int len);
        int        cx[4], cy[4], sx[4], sy[4];
        int        n_cl, c, jx, jy;
        t_box_word b;
        n_cl = $urandom_range(1, 4);
        for (int k = 0; k < 4; k++) begin
            cx[k] = $urandom_range(0, 60000);
            cy[k] = $urandom_range(0, 60000);
            sx[k] = $urandom_range(16, 4000);
            sy[k] = $urandom_range(16, 4000);
        end
        for (int i = 0; i < len; i++) begin
            c  = $urandom_range(0, n_cl - 1);
            jx = sx[c] / 3;
            jy = sy[c] / 3;
            b = mk_box(1'b0, $urandom_range(0, 2),
                       cx[c] + int'($urandom_range(0, jx)),
                       cy[c] + int'($urandom_range(0, jy)),
                       sx[c] - jx / 2 + int'($urandom_range(0, jx)),
                       sy[c] - jy / 2 + int'($urandom_range(0, jy)));
            case ($urandom_range(0, 19))
                0, 1: b = mk_box(1'b0, $urandom_range(0, 255), $urandom_range(0, 65535),
                                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 65535));
                2: b.width = '0;
                3: b.height = '0;
                default: ;
            endcase
            if (i == 0)
                b.first = ($urandom_range(0, 7) != 0);
            else
                b.first = ($urandom_range(0, 39) == 0);
            send_box(b);
        end
    endtask

    // A list of mutually disjoint boxes, one per grid cell, more than the store holds:
    // the first MAX_KEPT_DEF are stored and the rest come back kept with overflow set.
    // Repeats of stored boxes are then suppressed, while repeats of boxes that did not
    // fit are kept again, since nothing in the store covers them.
    task automatic send_crowded_list();
        t_box_word grid[272];
        int        j;
        for (int i = 0; i < 272; i++) begin
            grid[i] = mk_box(i == 0, $urandom_range(0, 255),
                             (i % 16) * 4096 + int'($urandom_range(0, 1000)),
                             (i / 16) * 3840 + int'($urandom_range(0, 500)),
                             $urandom_range(1, 3000), $urandom_range(1, 3000));
            send_box(grid[i]);
        end
        for (int k = 0; k < 12; k++) begin
            j = (k % 2 == 0) ? $urandom_range(0, MAX_KEPT_DEF - 1)
                             : $urandom_range(MAX_KEPT_DEF, 271);
            grid[j].first = 1'b0;
            send_box(grid[j]);
        end
    endtask

    // Result side: random readiness, plus one long hold-off on request, counted here
    // so the sender keeps offering boxes the whole time.
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                stall = receiver_stall();
                if (stall == 0) begin
                    m_axis_tready <= 1'b1;
                    @(posedge i_clk);
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        int               sent, len;
        logic [THR_W-1:0] thr;

        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= CFG_THRESHOLD;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, first under the reset settings (class-aware, IoU limit ~0.45).
        // A stream that starts without the first-box flag continues the empty list.
        send_box(mk_box(1'b0, 0, 0, 0, 0, 0));
        // Largest coordinates and sizes; a copy with the same label is suppressed,
        // one with another label is not compared at all.
        send_box(mk_box(1'b1, 255, 65535, 65535, 65535, 65535));
        send_box(mk_box(1'b0, 255, 65535, 65535, 65535, 65535));
        send_box(mk_box(1'b0, 254, 65535, 65535, 65535, 65535));
        // Two boxes that only touch at an edge have no intersection.
        send_box(mk_box(1'b0, 255, 0, 0, 16, 16));
        send_box(mk_box(1'b0, 255, 16, 0, 16, 16));
        // Empty boxes: zero width, zero height.
        send_box(mk_box(1'b0, 255, 0, 0, 0, 32));
        send_box(mk_box(1'b0, 255, 4, 4, 32, 0));
        // Half overlap with two kept boxes stays below the limit; a near copy does not.
        send_box(mk_box(1'b0, 255, 8, 0, 16, 16));
        send_box(mk_box(1'b0, 255, 2, 0, 16, 16));

        // Zero limit across all labels: any overlap at all suppresses, touching does
        // not, and an empty box survives on 0 > 0 being false.
        write_config(16'd0, 1'b1);
        send_box(mk_box(1'b1, 3, 100, 100, 40, 40));
        send_box(mk_box(1'b0, 9, 139, 139, 10, 10));
        send_box(mk_box(1'b0, 9, 140, 100, 10, 10));
        send_box(mk_box(1'b0, 9, 0, 0, 0, 0));
        send_box(mk_box(1'b0, 9, 100, 100, 40, 40));

        // Highest limit: only an exact copy exceeds it.
        write_config(16'd65535, 1'b0);
        send_box(mk_box(1'b1, 1, 500, 500, 64, 64));
        send_box(mk_box(1'b0, 1, 500, 500, 64, 64));
        send_box(mk_box(1'b0, 1, 500, 500, 64, 63));
        send_box(mk_box(1'b0, 2, 500, 500, 64, 64));

        // Random phases, each under its own settings. Phase 2 holds the result side
        // off for a long stretch, phase 3 runs with no idling on either side, phase 4
        // waits for every result after each list, phase 5 overflows the store.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: thr = 16'd0;
                1: thr = 16'd65535;
                2: thr = THRESHOLD_RESET;
                3: thr = 16'd32768;
                4: thr = 16'd1;
                default: thr = THR_W'($urandom_range(0, 65535));
            endcase
            write_config(thr, (p == 5) ? 1'($urandom_range(0, 1)) : 1'(p % 2));
            tx_idle_on = (p != 3);
            rx_idle_on = (p != 3);
            if (p == 2)
                hold_req = 1'b1;
            if (p == 5) begin
                send_crowded_list();
            end else begin
                sent = 0;
                while (sent < 45) begin
                    len = $urandom_range(1, 20);
                    send_random_list(len);
                    sent += len;
                    if (p == 4)
                        wait_drain();
                end
            end
        end

        wait_drain();
        repeat (300) @(posedge i_clk);
        if (errors == 0)
            $display("tb_greedy_box_suppression passed");
        else
            $display("tb_greedy_box_suppression failed");
        $finish;
    end

endmodule
